@@ sv/cpr_pkg.sv @@
// cpr_pkg: shared types, constants and helpers of the connection pair registry
// used by cpr_ram, cpr_ctrl and connection_pair_registry_top
`default_nettype none
package cpr_pkg;

  localparam int TableDepth = 64;
  localparam int NodeBits   = 16;
  localparam int MaxResults = 32;
  localparam int PortNodeW  = 16;
  localparam int InnovW     = 6;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int NumW       = $clog2(MaxResults + 1);
  localparam int MinBits    = (NodeBits < PortNodeW) ? NodeBits : PortNodeW;

  typedef logic [NodeBits-1:0]  node_t;
  typedef logic [PortNodeW-1:0] port_node_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [NumW-1:0]      num_t;
  typedef logic [InnovW-1:0]    innov_t;

  typedef struct packed {
    node_t src;
    node_t dst;
  } pair_t;

  typedef struct packed {
    logic  ren;
    idx_t  raddr;
    logic  wen;
    idx_t  waddr;
    pair_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic       strobe;
    innov_t     innov;
    logic       was_new;
    logic       full;
    port_node_t mid;
    logic       found;
    logic       last;
  } result_t;

  typedef enum logic {
    REQ_REGISTER,
    REQ_BETWEEN
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_SCAN,
    ST_BTW_OUTER,
    ST_BTW_INNER,
    ST_FINISH
  } state_e;

  function automatic node_t to_node(port_node_t p);
    node_t n;
    n = '0;
    for (int i = 0; i < MinBits; i++) begin
      n[i] = p[i];
    end
    return n;
  endfunction

  function automatic port_node_t to_port(node_t n);
    port_node_t p;
    p = '0;
    for (int i = 0; i < MinBits; i++) begin
      p[i] = n[i];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ sv/cpr_ram.sv @@
// cpr_ram: pair table, one write port and one registered read port
// depends on cpr_pkg
`default_nettype none
module cpr_ram (
  input  wire logic              clk_i,
  input  wire cpr_pkg::ram_req_t req_i,
  output      cpr_pkg::pair_t    rdata_o
);
  import cpr_pkg::*;

  pair_t mem [TableDepth];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wen) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.ren) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/cpr_ctrl.sv @@
// cpr_ctrl: request sequencer, table scans, append and result register
// depends on cpr_pkg, drives cpr_ram
`default_nettype none
module cpr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output      logic                busy_o,
  input  wire logic                req_type_i,
  input  wire cpr_pkg::port_node_t src_node_i,
  input  wire cpr_pkg::port_node_t dst_node_i,
  output      cpr_pkg::ram_req_t   ram_req_o,
  input  wire cpr_pkg::pair_t      rdata_i,
  output      cpr_pkg::result_t    res_o
);
  import cpr_pkg::*;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  cnt_t    ptr_q, ptr_d;
  cnt_t    resume_q, resume_d;
  logic    pend_q, pend_d;
  idx_t    pidx_q, pidx_d;
  node_t   s_q, s_d;
  node_t   d_q, d_d;
  node_t   x_q, x_d;
  logic    held_v_q, held_v_d;
  node_t   held_x_q, held_x_d;
  num_t    nfound_q, nfound_d;
  result_t res_q, res_d;
  logic    scan_issue, scan_done;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    resume_d  = resume_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    s_d       = s_q;
    d_d       = d_q;
    x_d       = x_q;
    held_v_d  = held_v_q;
    held_x_d  = held_x_q;
    nfound_d  = nfound_q;
    res_d     = '0;
    ram_req_o = '0;
    scan_issue = (ptr_q < count_q);
    scan_done  = !scan_issue && !pend_q;

    if (state_q == ST_REG_SCAN || state_q == ST_BTW_OUTER || state_q == ST_BTW_INNER) begin
      if (scan_issue) begin
        ram_req_o.ren   = 1'b1;
        ram_req_o.raddr = ptr_q[IdxW-1:0];
        ptr_d  = ptr_q + cnt_t'(1);
        pend_d = 1'b1;
        pidx_d = ptr_q[IdxW-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          s_d      = to_node(src_node_i);
          d_d      = to_node(dst_node_i);
          ptr_d    = '0;
          nfound_d = '0;
          held_v_d = 1'b0;
          state_d  = (req_e'(req_type_i) == REQ_BETWEEN) ? ST_BTW_OUTER : ST_REG_SCAN;
        end
      end
      ST_REG_SCAN: begin
        if (pend_q && rdata_i.src == s_q && rdata_i.dst == d_q) begin
          res_d.strobe = 1'b1;
          res_d.innov  = innov_t'(pidx_q);
          res_d.found  = 1'b1;
          res_d.last   = 1'b1;
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end else if (scan_done) begin
          res_d.strobe = 1'b1;
          res_d.last   = 1'b1;
          if (count_q == cnt_t'(TableDepth)) begin
            res_d.full = 1'b1;
          end else begin
            ram_req_o.wen       = 1'b1;
            ram_req_o.waddr     = count_q[IdxW-1:0];
            ram_req_o.wdata.src = s_q;
            ram_req_o.wdata.dst = d_q;
            count_d       = count_q + cnt_t'(1);
            res_d.innov   = innov_t'(count_q[IdxW-1:0]);
            res_d.was_new = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_BTW_OUTER: begin
        if (pend_q && rdata_i.dst == d_q) begin
          x_d      = rdata_i.src;
          resume_d = cnt_t'(pidx_q) + cnt_t'(1);
          ptr_d    = '0;
          pend_d   = 1'b0;
          state_d  = ST_BTW_INNER;
        end else if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_BTW_INNER: begin
        if (pend_q && rdata_i.src == s_q && rdata_i.dst == x_q) begin
          if (held_v_q) begin
            res_d.strobe = 1'b1;
            res_d.mid    = to_port(held_x_q);
            res_d.found  = 1'b1;
          end
          held_x_d = x_q;
          held_v_d = 1'b1;
          nfound_d = nfound_q + num_t'(1);
          pend_d   = 1'b0;
          ptr_d    = resume_q;
          if (nfound_q == num_t'(MaxResults - 1)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_BTW_OUTER;
          end
        end else if (scan_done) begin
          ptr_d   = resume_q;
          state_d = ST_BTW_OUTER;
        end
      end
      ST_FINISH: begin
        res_d.strobe = 1'b1;
        res_d.last   = 1'b1;
        if (held_v_q) begin
          res_d.mid   = to_port(held_x_q);
          res_d.found = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      held_v_q <= 1'b0;
      nfound_q <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      held_v_q <= held_v_d;
      nfound_q <= nfound_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    resume_q <= resume_d;
    pidx_q   <= pidx_d;
    s_q      <= s_d;
    d_q      <= d_d;
    x_q      <= x_d;
    held_x_q <= held_x_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.ren |-> cnt_t'(ram_req_o.raddr) < count_q)
    else $error("read beyond stored pairs");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.wen |=> count_q == $past(count_q) + cnt_t'(1) && res_q.was_new)
    else $error("append did not advance count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.wen |-> count_q < cnt_t'(TableDepth))
    else $error("append into full table");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.strobe && res_q.last |-> !busy_o)
    else $error("final word while still busy");

endmodule
`default_nettype wire

@@ sv/connection_pair_registry_top.sv @@
// connection_pair_registry_top: append-only pair registry with lookup and between listing
// depends on cpr_pkg, cpr_ram, cpr_ctrl
//
//   channel   handshake            payload
//   request   start && !busy       req_type_i, src_node_i, dst_node_i
//   result    strobe_o (one cycle) innov_number_o, was_new_o, table_full_o,
//                                  mid_node_o, found_o, last_o
//
// register request: one scan over the n stored pairs, then an append if none matches and the table has room,
// with the scan bound by the single read port
// between request: an outer scan and finish, plus an inner scan for each entry whose
// destination matches, until MaxResults mids are found, both scans through the same read port
// reset clears the entry count and the control state, not the table; the table needs no clearing pass
// results leave as one-cycle words, the receiver cannot stall them
`default_nettype none
module connection_pair_registry_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic                req_type_i,
  input  wire cpr_pkg::port_node_t src_node_i,
  input  wire cpr_pkg::port_node_t dst_node_i,
  output      logic                strobe_o,
  output      cpr_pkg::innov_t     innov_number_o,
  output      logic                was_new_o,
  output      logic                table_full_o,
  output      cpr_pkg::port_node_t mid_node_o,
  output      logic                found_o,
  output      logic                last_o
);
  import cpr_pkg::*;

  ram_req_t ram_req;
  pair_t    rdata;
  result_t  res;

  cpr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .req_type_i (req_type_i),
    .src_node_i (src_node_i),
    .dst_node_i (dst_node_i),
    .ram_req_o  (ram_req),
    .rdata_i    (rdata),
    .res_o      (res)
  );

  assign strobe_o       = res.strobe;
  assign innov_number_o = res.innov;
  assign was_new_o      = res.was_new;
  assign table_full_o   = res.full;
  assign mid_node_o     = res.mid;
  assign found_o        = res.found;
  assign last_o         = res.last;

endmodule
`default_nettype wire

@@ verif/tb_connection_pair_registry_top.sv @@
// tb_connection_pair_registry_top: self-checking bench for the connection pair registry
// a scoreboard class mirrors the pair table and predicts each result word, plain tasks drive
// depends on cpr_pkg and connection_pair_registry_top
module tb_connection_pair_registry_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  localparam int DirectedItems = 14;
  localparam int RandomItems   = 110;
  localparam int WatchLimit    = 20000;
  localparam int TailCycles    = 150;

  typedef struct packed {
    innov_t     innov;
    logic       was_new;
    logic       full;
    port_node_t mid;
    logic       found;
    logic       last;
  } pair_word_t;

  class pair_scoreboard;
    node_t       src_tab[TableDepth];
    node_t       dst_tab[TableDepth];
    int unsigned count;
    int unsigned errors;
    pair_word_t  pending_q[$];

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void enqueue(pair_word_t w);
      pending_q.insert(pending_q.size(), w);
    endfunction

    function bit find_pair(node_t s, node_t d, output int unsigned at);
      at = 0;
      for (int i = 0; i < count; i++) begin
        if (src_tab[i] == s && dst_tab[i] == d) begin
          at = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(req_e r, port_node_t s_in, port_node_t d_in);
      node_t       s;
      node_t       d;
      int unsigned at;
      int unsigned n;
      pair_word_t  w;
      s = node_t'(s_in);
      d = node_t'(d_in);
      w = '0;
      w.last = 1'b1;
      if (r == REQ_REGISTER) begin
        if (find_pair(s, d, at)) begin
          w.innov = innov_t'(at);
          w.found = 1'b1;
        end else if (count >= TableDepth) begin
          w.full = 1'b1;
        end else begin
          src_tab[count] = s;
          dst_tab[count] = d;
          w.innov = innov_t'(count);
          w.was_new = 1'b1;
          count++;
        end
        enqueue(w);
      end else begin
        n = 0;
        for (int j = 0; j < count; j++) begin
          if (dst_tab[j] == d && n < MaxResults && find_pair(s, src_tab[j], at)) begin
            w = '0;
            w.mid = port_node_t'(src_tab[j]);
            w.found = 1'b1;
            enqueue(w);
            n++;
          end
        end
        if (n == 0) begin
          w = '0;
          w.last = 1'b1;
          enqueue(w);
        end else begin
          w = pending_q.pop_back();
          w.last = 1'b1;
          enqueue(w);
        end
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(pair_word_t got);
      pair_word_t want;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("innov_number", 16'(want.innov), 16'(got.innov));
      compare_field("was_new", 16'(want.was_new), 16'(got.was_new));
      compare_field("table_full", 16'(want.full), 16'(got.full));
      compare_field("mid_node", want.mid, got.mid);
      compare_field("found", 16'(want.found), 16'(got.found));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       req_type_i;
  port_node_t src_node_i;
  port_node_t dst_node_i;
  logic       strobe_o;
  innov_t     innov_number_o;
  logic       was_new_o;
  logic       table_full_o;
  port_node_t mid_node_o;
  logic       found_o;
  logic       last_o;

  pair_scoreboard sb = new();
  int unsigned    items;
  int unsigned    burst_left;
  int unsigned    stall_cycles;
  port_node_t     node_pool[6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5A5A, 16'hA5A5};

  connection_pair_registry_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .src_node_i     (src_node_i),
    .dst_node_i     (dst_node_i),
    .strobe_o       (strobe_o),
    .innov_number_o (innov_number_o),
    .was_new_o      (was_new_o),
    .table_full_o   (table_full_o),
    .mid_node_o     (mid_node_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pair_word_t got;
    if (rst_ni && strobe_o) begin
      got.innov   = innov_number_o;
      got.was_new = was_new_o;
      got.full    = table_full_o;
      got.mid     = mid_node_o;
      got.found   = found_o;
      got.last    = last_o;
      sb.check_word(got);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchLimit) begin
        $display("connection_pair_registry_top: mismatch");
        $finish;
      end
    end
  end

  function automatic port_node_t pick_node();
    if ($urandom_range(0, 9) < 6) begin
      return node_pool[$urandom_range(0, 5)];
    end
    return port_node_t'($urandom);
  endfunction

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic send_word(req_e r, port_node_t s, port_node_t d);
    bit taken;
    pace();
    start      <= 1'b1;
    req_type_i <= r;
    src_node_i <= s;
    dst_node_i <= d;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    sb.note_request(r, s, d);
    items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register (s,x),(x,d) for k mids, shuffled; loose drops some, adds noise; then ask for mids
  task automatic run_star(port_node_t s, port_node_t d, int unsigned k, bit loose);
    port_node_t  ps[$];
    port_node_t  pd[$];
    port_node_t  x;
    port_node_t  t;
    int unsigned sw;
    for (int i = 0; i < k; i++) begin
      x = loose ? pick_node() : port_node_t'($urandom);
      ps.insert(ps.size(), s);
      pd.insert(pd.size(), x);
      ps.insert(ps.size(), x);
      pd.insert(pd.size(), d);
    end
    for (int i = ps.size() - 1; i > 0; i--) begin
      sw = $urandom_range(0, i);
      t = ps[i]; ps[i] = ps[sw]; ps[sw] = t;
      t = pd[i]; pd[i] = pd[sw]; pd[sw] = t;
    end
    for (int i = 0; i < ps.size(); i++) begin
      if (loose && $urandom_range(0, 7) == 0) begin
        send_word(REQ_REGISTER, pick_node(), pick_node());
      end
      if (!loose || $urandom_range(0, 9) != 0) begin
        send_word(REQ_REGISTER, ps[i], pd[i]);
      end
    end
    send_word(REQ_BETWEEN, s, d);
  endtask

  initial begin
    int unsigned kind;
    int unsigned k;
    bit          big_done;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = 1'b0;
    src_node_i   = '0;
    dst_node_i   = '0;
    items        = 0;
    burst_left   = 0;
    stall_cycles = 0;
    big_done     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, first entry, repeats and extreme node ids
    send_word(REQ_BETWEEN, 16'h0000, 16'h0000);
    send_word(REQ_REGISTER, 16'h0000, 16'h0000);
    send_word(REQ_REGISTER, 16'h0000, 16'h0000);
    send_word(REQ_REGISTER, 16'hFFFF, 16'hFFFF);
    send_word(REQ_REGISTER, 16'h0000, 16'hFFFF);
    send_word(REQ_BETWEEN, 16'h0000, 16'hFFFF);
    send_word(REQ_BETWEEN, 16'hFFFF, 16'h0000);
    send_word(REQ_REGISTER, 16'hFFFF, 16'h0000);
    send_word(REQ_BETWEEN, 16'hFFFF, 16'hFFFF);
    send_word(REQ_REGISTER, 16'h0001, 16'h0002);
    send_word(REQ_REGISTER, 16'h0002, 16'h0003);
    send_word(REQ_BETWEEN, 16'h0001, 16'h0003);
    send_word(REQ_BETWEEN, 16'h0003, 16'h0001);
    send_word(REQ_REGISTER, 16'hFFFF, 16'hFFFF);
    drain();

    while (items < DirectedItems + RandomItems) begin
      if (!big_done && items >= 70) begin
        k = (TableDepth - sb.count) / 2;
        if (k > 30) k = 30;
        if (k > 0) begin
          run_star(pick_node(), pick_node(), k, 1'b0);
        end
        big_done = 1'b1;
        drain();
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        run_star(pick_node(), pick_node(), $urandom_range(1, 5), 1'b1);
      end else if (kind < 7) begin
        send_word(REQ_REGISTER, pick_node(), pick_node());
      end else begin
        send_word(REQ_BETWEEN, pick_node(), pick_node());
      end
    end

    // overflow the table, then hit a stored pair and list once more
    while (sb.count < TableDepth) begin
      send_word(REQ_REGISTER, port_node_t'($urandom), port_node_t'($urandom));
    end
    send_word(REQ_REGISTER, port_node_t'($urandom), port_node_t'($urandom));
    send_word(REQ_REGISTER, 16'h0000, 16'h0000);
    send_word(REQ_BETWEEN, pick_node(), pick_node());
    drain();
    repeat (TailCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("connection_pair_registry_top: match");
    end else begin
      $display("connection_pair_registry_top: mismatch");
    end
    $finish;
  end

endmodule
